### hdl/slt_pkg.sv
// Shared constants, codes and types for the sorted list table.
package slt_pkg;

   // Table size and derived widths
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths of the request and response
   localparam int OP_W     = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int OCC_W    = 5;

   localparam int REQ_TDATA_W = ((OP_W + VALUE_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((STATUS_W + POS_W + OCC_W + 7) / 8) * 8;

   // Opcodes; code 3 is unused and answers as a miss
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_INS_RD,
      S_INS_WR,
      S_INS_PUT,
      S_REM_RD,
      S_REM_WR,
      S_DONE
   } slt_state_type;

endpackage

### hdl/sorted_list_table_core.sv
// Sorted list table: ascending table of signed 32-bit values with insert, remove, search.
//
// The block keeps up to slt_pkg::CAPACITY signed 32-bit values in ascending
// order in a small RAM. A request carries an opcode and a value: insert puts
// the value ahead of the first entry that is not smaller (equal values are
// kept, newest first), remove deletes the first equal entry, search looks for
// an equal entry. Each request gives exactly one response with a status
// (done/found, not found, or full on insert), the sorted position of the
// entry that was touched (0 when none) and the occupancy after the request.
// Opcode 3 is a no-op answered as not found. Work is done by one comparator
// and one RAM read port under a sequencer, one request at a time: req_tready
// is high only while the sequencer is idle. Insert scans for its slot, opens a
// gap from the tail down and writes the value; remove scans for its match and
// closes the gap up to the tail, so the scan and the gap closing together walk
// the whole table on a hit or a miss; search stops at its first hit. A
// full-table insert or opcode 3 goes straight to the response. The longest
// request is an insert into 15 entries. Every compare and every move takes a
// read state and a second state because the RAM read data is registered. The
// response sits in an output register, so a stalled rsp_tready does not block
// the next request from being accepted; only the following response waits.
// There is no clearing pass after reset: only entries below the occupancy are
// ever read.
module sorted_list_table_core (
   input  logic                                clock,
   input  logic                                reset,
   // request: [1:0] opcode, [33:2] value, upper bits zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [slt_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // response: [1:0] status, [5:2] position, [10:6] occupancy, upper bits zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [slt_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   slt_pkg::slt_state_type state_ff, state_in;

   logic [slt_pkg::OP_W-1:0]        op_ff, op_in;
   logic signed [slt_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [slt_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [slt_pkg::CNT_W-1:0]       idx_ff, idx_in;     // scan index, then shift index
   logic [slt_pkg::IDX_W-1:0]       pos_ff, pos_in;
   logic [slt_pkg::STATUS_W-1:0]    status_ff, status_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [slt_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [slt_pkg::POS_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [slt_pkg::OCC_W-1:0]       rsp_occ_ff, rsp_occ_in;

   // RAM port signals
   logic                            ram_wr_en;
   logic [slt_pkg::IDX_W-1:0]       ram_wr_addr;
   logic [slt_pkg::VALUE_W-1:0]     ram_wr_data;
   logic                            ram_rd_en;
   logic [slt_pkg::IDX_W-1:0]       ram_rd_addr;
   logic [slt_pkg::VALUE_W-1:0]     ram_rd_data;

   // Shared compare unit: stored entry against the request value
   logic signed [slt_pkg::VALUE_W-1:0] entry;
   logic                            ent_lt;
   logic                            ent_eq;
   logic                            hit;

   logic [slt_pkg::CNT_W-1:0]       idx_inc;
   logic [slt_pkg::CNT_W-1:0]       idx_dec;
   logic                            rsp_load;

   slt_ram #(
      .Width (slt_pkg::VALUE_W),
      .Depth (slt_pkg::CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign entry   = signed'(ram_rd_data);
   assign ent_lt  = entry < value_ff;
   assign ent_eq  = entry == value_ff;
   // insert stops at the first entry not smaller; remove/search at the first equal
   assign hit     = (op_ff == slt_pkg::OP_INSERT) ? !ent_lt : ent_eq;

   assign idx_inc = idx_ff + 1'b1;
   assign idx_dec = idx_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slt_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // Sequencer: next state, datapath controls and RAM port
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      value_in    = value_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      status_in   = status_ff;
      req_tready  = 1'b0;
      rsp_load    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[slt_pkg::IDX_W-1:0];
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[slt_pkg::IDX_W-1:0];

      case (state_ff)
         slt_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in    = req_tdata[slt_pkg::OP_W-1:0];
               value_in = signed'(req_tdata[slt_pkg::OP_W +: slt_pkg::VALUE_W]);
               idx_in   = '0;
               pos_in   = '0;
               case (req_tdata[slt_pkg::OP_W-1:0])
                  slt_pkg::OP_INSERT: begin
                     if (count_ff == slt_pkg::CNT_W'(slt_pkg::CAPACITY)) begin
                        status_in = slt_pkg::ST_FULL;
                        state_in  = slt_pkg::S_DONE;
                     end else begin
                        state_in  = slt_pkg::S_SCAN_RD;
                     end
                  end
                  slt_pkg::OP_REMOVE, slt_pkg::OP_SEARCH: begin
                     state_in = slt_pkg::S_SCAN_RD;
                  end
                  default: begin
                     status_in = slt_pkg::ST_MISS;
                     state_in  = slt_pkg::S_DONE;
                  end
               endcase
            end
         end

         slt_pkg::S_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               // ran off the end: insert appends, others miss
               if (op_ff == slt_pkg::OP_INSERT) begin
                  pos_in   = idx_ff[slt_pkg::IDX_W-1:0];
                  state_in = slt_pkg::S_INS_RD;
               end else begin
                  status_in = slt_pkg::ST_MISS;
                  state_in  = slt_pkg::S_DONE;
               end
            end else begin
               ram_rd_en = 1'b1;
               state_in  = slt_pkg::S_SCAN_CMP;
            end
         end

         slt_pkg::S_SCAN_CMP: begin
            if (hit) begin
               pos_in = idx_ff[slt_pkg::IDX_W-1:0];
               case (op_ff)
                  slt_pkg::OP_INSERT: begin
                     idx_in   = count_ff;
                     state_in = slt_pkg::S_INS_RD;
                  end
                  slt_pkg::OP_REMOVE: begin
                     state_in = slt_pkg::S_REM_RD;
                  end
                  default: begin
                     status_in = slt_pkg::ST_OK;
                     state_in  = slt_pkg::S_DONE;
                  end
               endcase
            end else begin
               idx_in   = idx_inc;
               state_in = slt_pkg::S_SCAN_RD;
            end
         end

         // open a gap: entries[j] = entries[j-1] for j from count down to pos+1
         slt_pkg::S_INS_RD: begin
            if (idx_ff == slt_pkg::CNT_W'(pos_ff)) begin
               state_in = slt_pkg::S_INS_PUT;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_dec[slt_pkg::IDX_W-1:0];
               state_in    = slt_pkg::S_INS_WR;
            end
         end

         slt_pkg::S_INS_WR: begin
            ram_wr_en = 1'b1;
            idx_in    = idx_dec;
            state_in  = slt_pkg::S_INS_RD;
         end

         slt_pkg::S_INS_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff;
            ram_wr_data = value_ff;
            count_in    = count_ff + 1'b1;
            status_in   = slt_pkg::ST_OK;
            state_in    = slt_pkg::S_DONE;
         end

         // close the gap: entries[j] = entries[j+1] up to the old tail
         slt_pkg::S_REM_RD: begin
            if (idx_inc == count_ff) begin
               count_in  = count_ff - 1'b1;
               status_in = slt_pkg::ST_OK;
               state_in  = slt_pkg::S_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_inc[slt_pkg::IDX_W-1:0];
               state_in    = slt_pkg::S_REM_WR;
            end
         end

         slt_pkg::S_REM_WR: begin
            ram_wr_en = 1'b1;
            idx_in    = idx_inc;
            state_in  = slt_pkg::S_REM_RD;
         end

         slt_pkg::S_DONE: begin
            // hand off to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = slt_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = slt_pkg::S_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_pos_in    = slt_pkg::POS_W'(pos_ff);
         rsp_occ_in    = slt_pkg::OCC_W'(count_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = slt_pkg::RSP_TDATA_W'({rsp_occ_ff, rsp_pos_ff, rsp_status_ff});

endmodule

### hdl/slt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slt_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/slt_checker.sv
// Port-level checker for the sorted list table, bound to the top level.
module slt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [slt_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   logic [slt_pkg::STATUS_W-1:0] rsp_status;
   logic [slt_pkg::POS_W-1:0]    rsp_pos;
   logic [slt_pkg::OCC_W-1:0]    rsp_occ;

   assign rsp_status = rsp_tdata[slt_pkg::STATUS_W-1:0];
   assign rsp_pos    = rsp_tdata[slt_pkg::STATUS_W +: slt_pkg::POS_W];
   assign rsp_occ    = rsp_tdata[slt_pkg::STATUS_W + slt_pkg::POS_W +: slt_pkg::OCC_W];

   // one request at a time: the sequencer leaves idle on acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous one in progress");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   // position is only reported on success
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status != slt_pkg::ST_OK) |-> (rsp_pos == '0))
      else $error("nonzero position on miss or full");

   // full is reported only with a full table
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == slt_pkg::ST_FULL)
         |-> (rsp_occ == slt_pkg::OCC_W'(slt_pkg::CAPACITY)))
      else $error("full status with table not full");

   // status never takes the unused code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_status == slt_pkg::ST_OK || rsp_status == slt_pkg::ST_MISS
                      || rsp_status == slt_pkg::ST_FULL))
      else $error("bad status code");

endmodule

bind sorted_list_table_core slt_checker u_slt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### bench/slt_reply_checker.sv
`timescale 1ns / 100ps
// Response checker for the sorted list table: mirrors the table and compares every response.
module slt_reply_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [slt_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [slt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                              mismatches,
   output int                              owed_count
);

   localparam int FIELDS_W = slt_pkg::STATUS_W + slt_pkg::POS_W + slt_pkg::OCC_W;

   // status sits in the low bits, as on the bus
   typedef struct packed {
      logic [slt_pkg::OCC_W-1:0]    occupancy;
      logic [slt_pkg::POS_W-1:0]    position;
      logic [slt_pkg::STATUS_W-1:0] status;
   } table_reply_type;

   logic signed [slt_pkg::VALUE_W-1:0] held_vals [slt_pkg::CAPACITY];
   int                                 held;
   table_reply_type                    owed_replies [$];

   task automatic log_error(input string msg);
      $display("%0t checker: %s", $time, msg);
      mismatches++;
   endtask

   // Applies one request to the mirrored table and returns the response it owes.
   function automatic table_reply_type table_apply(
      input logic [slt_pkg::OP_W-1:0]            op,
      input logic signed [slt_pkg::VALUE_W-1:0]  v);
      table_reply_type r;
      int              slot;
      r.status = slt_pkg::ST_MISS;
      slot     = 0;
      case (op)
         slt_pkg::OP_INSERT: begin
            if (held >= slt_pkg::CAPACITY) begin
               r.status = slt_pkg::ST_FULL;
            end else begin
               while (slot < held && held_vals[slot] < v) slot++;
               for (int i = held; i > slot; i--) held_vals[i] = held_vals[i-1];
               held_vals[slot] = v;
               held++;
               r.status = slt_pkg::ST_OK;
            end
         end
         slt_pkg::OP_REMOVE, slt_pkg::OP_SEARCH: begin
            while (slot < held && held_vals[slot] != v) slot++;
            if (slot < held) begin
               r.status = slt_pkg::ST_OK;
               if (op == slt_pkg::OP_REMOVE) begin
                  for (int i = slot; i + 1 < held; i++) held_vals[i] = held_vals[i+1];
                  held--;
               end
            end
         end
         default: ;
      endcase
      if (r.status != slt_pkg::ST_OK) slot = 0;
      r.position  = slot[slt_pkg::POS_W-1:0];
      r.occupancy = held[slt_pkg::OCC_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      table_reply_type want;
      table_reply_type got;
      if (reset) begin
         held = 0;
         owed_replies.delete();
      end else begin
         // responses first: the queue head is always an older request
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[FIELDS_W-1:0];
            if (owed_replies.size() == 0) begin
               log_error($sformatf("response %h with no request outstanding", rsp_tdata));
            end else begin
               want = owed_replies.pop_front();
               if (got.status != want.status)
                  log_error($sformatf("status %0d, want %0d", got.status, want.status));
               if (got.position != want.position)
                  log_error($sformatf("position %0d, want %0d", got.position, want.position));
               if (got.occupancy != want.occupancy)
                  log_error($sformatf("occupancy %0d, want %0d",
                                      got.occupancy, want.occupancy));
               if (rsp_tdata[slt_pkg::RSP_TDATA_W-1:FIELDS_W] != '0)
                  log_error($sformatf("nonzero pad bits in response %h", rsp_tdata));
            end
         end
         if (req_tvalid && req_tready)
            owed_replies.push_back(table_apply(req_tdata[slt_pkg::OP_W-1:0],
                                               req_tdata[slt_pkg::OP_W +: slt_pkg::VALUE_W]));
      end
      owed_count <= owed_replies.size();
   end

endmodule

### bench/sorted_list_table_core_tb.sv
`timescale 1ns / 100ps
// Top of the sorted list table testbench: clock, reset, request stimulus, receiver and verdict.
module sorted_list_table_core_tb;

   // Opcode 3 has no name in the package; the block answers it as a miss.
   localparam logic [slt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   localparam logic [slt_pkg::VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
   localparam logic [slt_pkg::VALUE_W-1:0] VAL_MAX = 32'h7fff_ffff;

   localparam int RANDOM_ITEMS = 1300;
   localparam int PHASE_LEN    = 100;   // requests per idling phase
   localparam int FILL_LEN     = 80;    // requests per fill or drain stretch
   localparam int LONG_HOLD    = 400;   // receiver hold-off, in cycles
   // Leave margin after the last response, beyond the worst request.
   localparam int DRAIN_CYCLES = 100;
   // Watchdog limit on the whole run, well above the slowest honest run.
   localparam int CYCLE_LIMIT  = 1_000_000;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   // request: [1:0] opcode, [33:2] value, upper bits zero
   logic [slt_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // response: [1:0] status, [5:2] position, [10:6] occupancy, upper bits zero
   logic [slt_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   int mismatches;
   int owed_count;

   // Idling knobs. The sender one is used only by the stimulus process.
   int   sender_idle_pct    = 0;
   int   receiver_stall_pct = 0;
   // Each flip of hold_token asks the receiver for one long hold-off.
   logic hold_token = 1'b0;
   logic hold_seen  = 1'b0;
   int   hold_left  = 0;

   int   cycle_count = 0;

   sorted_list_table_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   slt_reply_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .owed_count (owed_count)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: random stalls, plus the long hold-off that backs the block up.
   // While held, the output register fills, one more request is taken in, and
   // req_tready then stays low until the hold ends.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_seen  <= hold_token;
      end else if (hold_token != hold_seen) begin
         hold_seen  <= hold_token;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Offer one request and return at the edge that accepts it. tvalid is left
   // high, so back-to-back requests never drop it within one time step.
   task automatic send_request(input logic [slt_pkg::OP_W-1:0]    op,
                               input logic [slt_pkg::VALUE_W-1:0] val);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= slt_pkg::REQ_TDATA_W'({val, op});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Watchdog: a hung block or a lost response ends here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [slt_pkg::OP_W-1:0]    op;
      logic [slt_pkg::VALUE_W-1:0] val;
      logic [slt_pkg::VALUE_W-1:0] recent [16];
      int                          recent_ix;
      int                          sel;
      bit                          filling;

      recent_ix = 0;
      foreach (recent[i]) recent[i] = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // ---- Directed part, no idling ----
      // empty table: misses and the unused opcode
      send_request(slt_pkg::OP_SEARCH, 32'd5);
      send_request(slt_pkg::OP_REMOVE, 32'd5);
      send_request(OP_UNUSED, 32'hffff_ffff);
      // removing the only entry
      send_request(slt_pkg::OP_INSERT, 32'd7);
      send_request(slt_pkg::OP_REMOVE, 32'd7);
      // extremes, then a duplicate that must land ahead of its equal
      send_request(slt_pkg::OP_INSERT, VAL_MAX);
      send_request(slt_pkg::OP_INSERT, VAL_MIN);
      send_request(slt_pkg::OP_INSERT, 32'd0);
      send_request(slt_pkg::OP_INSERT, 32'hffff_ffff);
      send_request(slt_pkg::OP_INSERT, 32'd0);
      send_request(slt_pkg::OP_SEARCH, 32'd0);
      // removing the tail, then looking for it in a non-empty table
      send_request(slt_pkg::OP_REMOVE, VAL_MAX);
      send_request(slt_pkg::OP_SEARCH, VAL_MAX);
      // fill to capacity with descending values so every insert after the first shifts
      for (int k = 0; k < slt_pkg::CAPACITY - 4; k++)
         send_request(slt_pkg::OP_INSERT, 32'(100 - k));
      // insert into a full table, then remove the head of a full table
      send_request(slt_pkg::OP_INSERT, 32'd3);
      send_request(slt_pkg::OP_REMOVE, VAL_MIN);

      // ---- Random part ----
      // Fill and drain stretches alternate so the table spends time both
      // near empty and at capacity; values mostly come from a small pool or
      // from earlier inserts so removes and searches actually hit.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_LEN == 0) begin
            case ((n / PHASE_LEN) % 4)
               0: begin sender_idle_pct = 0;  receiver_stall_pct <= 0;  end
               1: begin sender_idle_pct = 72; receiver_stall_pct <= 0;  end
               2: begin sender_idle_pct = 0;  receiver_stall_pct <= 72; end
               default: begin sender_idle_pct = 9; receiver_stall_pct <= 9; end
            endcase
         end
         // long receiver hold-off while the sender keeps pushing
         if (n == RANDOM_ITEMS / 2 + 50) hold_token <= ~hold_token;

         filling = ((n / FILL_LEN) % 2 == 0);
         sel = $urandom_range(0, 99);
         if (sel < 5)                          op = OP_UNUSED;
         else if (sel < (filling ? 65 : 25))   op = slt_pkg::OP_INSERT;
         else if (sel < (filling ? 85 : 80))   op = slt_pkg::OP_REMOVE;
         else                                  op = slt_pkg::OP_SEARCH;

         sel = $urandom_range(0, 99);
         if (sel < 40) begin
            val = $urandom_range(0, 8) - 4;
         end else if (sel < 55) begin
            val = recent[4'($urandom_range(0, 15))];
         end else if (sel < 70) begin
            case ($urandom_range(0, 5))
               0:       val = VAL_MIN;
               1:       val = VAL_MAX;
               2:       val = VAL_MIN + 1;
               3:       val = VAL_MAX - 1;
               4:       val = 32'hffff_ffff;
               default: val = '0;
            endcase
         end else begin
            val = $urandom;
         end

         if (op == slt_pkg::OP_INSERT) begin
            recent[recent_ix] = val;
            recent_ix = (recent_ix + 1) % 16;
         end
         send_request(op, val);
      end

      // ---- Drain ----
      // Still in the step of the last acceptance: drop valid exactly once.
      req_tvalid         <= 1'b0;
      receiver_stall_pct <= 0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && owed_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### files.f
hdl/slt_pkg.sv
hdl/slt_ram.sv
hdl/sorted_list_table_core.sv
hdl/slt_checker.sv
bench/slt_reply_checker.sv
bench/sorted_list_table_core_tb.sv
